// ===== rtl/core/roc_pkg.sv =====
// shared types and constants of the rational open circuit potential unit
package roc_pkg;

  localparam int ACC_W   = 40;  // signed Q.16 accumulator of the curve
  localparam int XI_W    = 18;  // unsigned Q.16 normalized content
  localparam int IFRAC   = 16;
  localparam int RECIP_W = 24;
  localparam int GROUP_W = 32;
  localparam int TYPE_W  = 8;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 2;
  localparam int QFRAC   = 24;  // fraction bits of the potential

  typedef enum logic [IDX_W-1:0] {
    REG_GROUP_SELECT = 2'd0,
    REG_ACTIVE_TYPE  = 2'd1,
    REG_MAX_RECIP    = 2'd2
  } roc_reg_t;

  // numerator and denominator coefficients, highest power first, Q.16
  localparam logic signed [ACC_W-1:0] NUM_COEF [5] = '{
    -40'sd1160599471, 40'sd3248195421, -40'sd5547021408,
    -40'sd326427570, 40'sd3732993361
  };
  localparam logic signed [ACC_W-1:0] DEN_COEF [4] = '{
    40'sd65536, -40'sd943192933, 40'sd107564386, 40'sd820892913
  };

  // side information that travels down the chain with each item
  typedef struct packed {
    logic valid;
    logic written;
    logic sat;
    logic neg;
    logic dzero;
    logic nneg;
  } roc_flags_t;

endpackage

// ===== rtl/core/roc_horner_cell.sv =====
// one horner step of numerator and, when DSTEP is set, denominator, registered
module roc_horner_cell import roc_pkg::*; #(
  parameter logic signed [ACC_W-1:0] NCOEF = '0,
  parameter logic signed [ACC_W-1:0] DCOEF = '0,
  parameter bit DSTEP = 1'b1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  roc_flags_t              flags_in,
  input  logic [XI_W-1:0]         xi_in,
  input  logic signed [ACC_W-1:0] nacc_in,
  input  logic signed [ACC_W-1:0] dacc_in,
  output roc_flags_t              flags_out,
  output logic [XI_W-1:0]         xi_out,
  output logic signed [ACC_W-1:0] nacc_out,
  output logic signed [ACC_W-1:0] dacc_out
);

  localparam int PW = ACC_W + XI_W;

  // round(a * x / 2^16), halves away from zero
  function automatic logic signed [ACC_W-1:0] mul_q(input logic signed [ACC_W-1:0] a,
                                                    input logic [XI_W-1:0] x);
    logic [ACC_W-1:0] mag;
    logic [PW-1:0]    prod;
    logic [PW-1:0]    rnd;
    logic [ACC_W-1:0] r;
    mag  = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    prod = PW'(mag) * PW'(x);
    rnd  = prod + PW'(1 << (IFRAC - 1));
    r    = rnd[IFRAC +: ACC_W];
    return a[ACC_W-1] ? -$signed(r) : $signed(r);
  endfunction

  logic signed [ACC_W-1:0] nacc_next, dacc_next;

  always_comb begin
    nacc_next = mul_q(nacc_in, xi_in) + NCOEF;
    dacc_next = DSTEP ? mul_q(dacc_in, xi_in) + DCOEF : dacc_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_out <= '0;
    end else if (en) begin
      flags_out <= flags_in;
    end
    if (en) begin
      xi_out   <= xi_in;
      nacc_out <= nacc_next;
      dacc_out <= dacc_next;
    end
  end

endmodule

// ===== rtl/core/roc_div_cell.sv =====
// one restoring division step: decides quotient bit K
module roc_div_cell import roc_pkg::*; #(
  parameter int RW = 65,
  parameter int MW = 40,
  parameter int QW = 33,
  parameter int K  = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  roc_flags_t    flags_in,
  input  logic [RW-1:0] rem_in,
  input  logic [MW-1:0] md_in,
  input  logic [QW-1:0] q_in,
  output roc_flags_t    flags_out,
  output logic [RW-1:0] rem_out,
  output logic [MW-1:0] md_out,
  output logic [QW-1:0] q_out
);

  localparam int CMPW = ((MW + K) > RW) ? (MW + K + 1) : (RW + 1);

  logic [CMPW-1:0] sub;
  logic [CMPW-1:0] rem_x;
  logic            take;
  logic [RW-1:0]   rem_next;
  logic [QW-1:0]   q_next;

  always_comb begin
    sub      = CMPW'(md_in) << K;
    rem_x    = CMPW'(rem_in);
    take     = rem_x >= sub;
    rem_next = take ? RW'(rem_x - sub) : rem_in;
    q_next   = q_in;
    q_next[K] = take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_out <= '0;
    end else if (en) begin
      flags_out <= flags_in;
    end
    if (en) begin
      rem_out <= rem_next;
      md_out  <= md_in;
      q_out   <= q_next;
    end
  end

endmodule

// ===== rtl/core/rational_open_circuit_potential_unit.sv =====
// top level: content scaling, horner cell chain, divider cell chain, output register
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata {group_bits, content}, tuser particle_type
// m_*       out  m_tvalid/m_tready  tdata potential, tuser {saturated, written}
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// one particle per cycle while the output is not held; the chain is made of
// scaling (2), horner cells (4), divider setup (1), one divider cell per
// quotient bit (POTENTIAL_WIDTH + 1) and the output register
// synchronous reset empties the chain and loads the register defaults
// a held output stalls the whole chain; s_tready follows from it
module rational_open_circuit_potential_unit import roc_pkg::*; #(
  parameter int CONTENT_WIDTH   = 16,
  parameter int POTENTIAL_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // content, group_bits
  input  logic [((CONTENT_WIDTH+GROUP_W+7)/8)*8-1:0] s_tdata,
  // particle_type
  input  logic [TYPE_W-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // potential
  output logic [((POTENTIAL_WIDTH+7)/8)*8-1:0] m_tdata,
  // written, saturated
  output logic [1:0] m_tuser,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CW   = CONTENT_WIDTH;
  localparam int PW   = POTENTIAL_WIDTH;
  localparam int SDW  = ((CW + GROUP_W + 7) / 8) * 8;
  localparam int MDW  = ((PW + 7) / 8) * 8;
  localparam int PRW  = CW + RECIP_W;
  localparam int XNW  = PRW - IFRAC + 1;
  localparam int RW   = ACC_W + QFRAC + 1;
  localparam int QW   = PW + 1;
  localparam int NDIV = PW + 1;

  logic [GROUP_W-1:0] group_select;
  logic [TYPE_W-1:0]  active_type;
  logic [RECIP_W-1:0] max_recip;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_select <= GROUP_W'(1);
      active_type  <= TYPE_W'(1);
      max_recip    <= RECIP_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GROUP_SELECT: group_select <= cfg_data[GROUP_W-1:0];
        REG_ACTIVE_TYPE:  active_type  <= cfg_data[TYPE_W-1:0];
        REG_MAX_RECIP:    max_recip    <= cfg_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage a: selection and scaling product
  roc_flags_t     fa;
  roc_flags_t     fa_next;
  logic [PRW-1:0] prod_a;
  logic           sel;

  assign sel = ((s_tdata[CW +: GROUP_W] & group_select) != '0) && (s_tuser == active_type);

  always_comb begin
    fa_next         = '0;
    fa_next.valid   = s_tvalid;
    fa_next.written = sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fa <= '0;
    end else if (adv) begin
      fa <= fa_next;
    end
    if (adv) begin
      prod_a <= PRW'(s_tdata[CW-1:0]) * PRW'(max_recip);
    end
  end

  // stage b: round, clip, bring to Q.16
  roc_flags_t      fb;
  roc_flags_t      fb_next;
  logic [XI_W-1:0] xi_b;
  logic [PRW-1:0]  prnd;
  logic [XNW-1:0]  xn_full;
  logic [CW-1:0]   xn;
  logic            clip;
  logic [XI_W-1:0] xi_next;

  always_comb begin
    prnd    = prod_a + PRW'(1 << (IFRAC - 1));
    xn_full = XNW'(prnd >> IFRAC);
    clip    = xn_full > XNW'({CW{1'b1}});
    xn      = clip ? {CW{1'b1}} : xn_full[CW-1:0];
    fb_next     = fa;
    fb_next.sat = fa.written && clip;
  end

  generate
    if (CW - 1 > IFRAC) begin : g_narrow
      localparam int SH = CW - 1 - IFRAC;
      logic [CW:0] xr;
      assign xr      = {1'b0, xn} + (CW+1)'(1 << (SH - 1));
      assign xi_next = XI_W'(xr >> SH);
    end else begin : g_widen
      assign xi_next = XI_W'(xn) << (IFRAC - (CW - 1));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      fb <= '0;
    end else if (adv) begin
      fb <= fb_next;
    end
    if (adv) begin
      xi_b <= xi_next;
    end
  end

  // horner cell chain
  roc_flags_t              hf [5];
  logic [XI_W-1:0]         hx [5];
  logic signed [ACC_W-1:0] hn [5];
  logic signed [ACC_W-1:0] hd [5];

  assign hf[0] = fb;
  assign hx[0] = xi_b;
  assign hn[0] = NUM_COEF[0];
  assign hd[0] = DEN_COEF[0];

  for (genvar i = 0; i < 4; i++) begin : g_horner
    roc_horner_cell #(
      .NCOEF(NUM_COEF[i+1]),
      .DCOEF((i < 3) ? DEN_COEF[(i < 3) ? i + 1 : 0] : '0),
      .DSTEP(i < 3)
    ) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .flags_in(hf[i]), .xi_in(hx[i]), .nacc_in(hn[i]), .dacc_in(hd[i]),
      .flags_out(hf[i+1]), .xi_out(hx[i+1]), .nacc_out(hn[i+1]), .dacc_out(hd[i+1])
    );
  end

  // divider setup: magnitudes and rounding offset
  roc_flags_t       df [NDIV+1];
  logic [RW-1:0]    dr [NDIV+1];
  logic [ACC_W-1:0] dm [NDIV+1];
  logic [QW-1:0]    dq [NDIV+1];
  logic [ACC_W-1:0] mn, md;
  roc_flags_t       ds_next;

  always_comb begin
    mn = hn[4][ACC_W-1] ? ACC_W'(-hn[4]) : ACC_W'(hn[4]);
    md = hd[4][ACC_W-1] ? ACC_W'(-hd[4]) : ACC_W'(hd[4]);
    ds_next       = hf[4];
    ds_next.neg   = hn[4][ACC_W-1] != hd[4][ACC_W-1];
    ds_next.dzero = hd[4] == '0;
    ds_next.nneg  = !hn[4][ACC_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      df[0] <= '0;
    end else if (adv) begin
      df[0] <= ds_next;
    end
    if (adv) begin
      dr[0] <= (RW'(mn) << QFRAC) + RW'(md >> 1);
      dm[0] <= md;
      dq[0] <= '0;
    end
  end

  // one cell per quotient bit, top bit flags overflow
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    roc_div_cell #(.RW(RW), .MW(ACC_W), .QW(QW), .K(PW - j)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .flags_in(df[j]), .rem_in(dr[j]), .md_in(dm[j]), .q_in(dq[j]),
      .flags_out(df[j+1]), .rem_out(dr[j+1]), .md_out(dm[j+1]), .q_out(dq[j+1])
    );
  end

  // final clip, sign and output register
  roc_flags_t    ff;
  logic [QW-1:0] lim, qc;
  logic [PW-1:0] pot;
  logic          sat_f;

  assign ff = df[NDIV];

  always_comb begin
    lim   = ff.neg ? QW'(1) << (PW - 1) : (QW'(1) << (PW - 1)) - QW'(1);
    sat_f = ff.sat;
    qc    = dq[NDIV];
    if (qc > lim) begin
      qc    = lim;
      sat_f = 1'b1;
    end
    pot = ff.neg ? PW'(-qc) : PW'(qc);
    if (ff.dzero) begin
      sat_f = 1'b1;
      pot   = ff.nneg ? {1'b0, {(PW-1){1'b1}}} : {1'b1, {(PW-1){1'b0}}};
    end
    if (!ff.written) begin
      sat_f = 1'b0;
      pot   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= ff.valid;
    end
    if (adv) begin
      m_tdata <= MDW'($signed(pot));
      m_tuser <= {sat_f, ff.written};
    end
  end

endmodule

// ===== rtl/core/roc_checker.sv =====
// port checker for the rational open circuit potential unit
module roc_checker #(
  parameter int POTENTIAL_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((POTENTIAL_WIDTH+7)/8)*8-1:0] m_tdata,
  input logic [1:0] m_tuser
);

  // unselected particles carry a clean zero result
  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
    else $error("unwritten result not zero");

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // chain empties on reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // input side is open whenever the output side is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input blocked with free output");

endmodule

bind rational_open_circuit_potential_unit roc_checker #(
  .POTENTIAL_WIDTH(POTENTIAL_WIDTH)
) u_roc_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
